FILE: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, operation and status codes, and the result bundle of the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Store geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 11;

  // Operation codes; the unused codes behave as a query
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // One result item as it travels from the controller to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] front_value;
    logic                     is_empty;
    logic [SIZE_W-1:0]        size;
  } dq_res_t;

endpackage

FILE: hdl/dq_req_if.sv
// ----------------------------------------------------------------------------
// dq_req_if
// Request channel: one operation code and one value per transfer.
// ----------------------------------------------------------------------------
interface dq_req_if;

  logic                              valid;
  logic                              ready;
  logic [dq_pkg::OP_W-1:0]           op;
  logic signed [dq_pkg::DATA_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);

endinterface

FILE: hdl/dq_rsp_if.sv
// ----------------------------------------------------------------------------
// dq_rsp_if
// Response channel: status, front element, empty flag and element count.
// ----------------------------------------------------------------------------
interface dq_rsp_if;

  logic                                valid;
  logic                                ready;
  logic [dq_pkg::STATUS_W-1:0]         status;
  logic signed [dq_pkg::DATA_W-1:0]    front_value;
  logic                                is_empty;
  logic [dq_pkg::SIZE_W-1:0]           size;

  modport source (output valid, output status, output front_value,
                  output is_empty, output size, input ready);
  modport sink   (input valid, input status, input front_value,
                  input is_empty, input size, output ready);

endinterface

FILE: hdl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Pointer and count keeper of the double-ended queue. Holds the front index,
// the element count and a copy of the front element, writes pushed values
// into the element RAM and reads the new front element after a front pop.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  dq_req_if.sink                        req,
  input  logic                          out_free,
  output logic                          res_valid,
  output dq_pkg::dq_res_t               res,
  output logic                          ram_we,
  output logic [dq_pkg::ADDR_W-1:0]     ram_waddr,
  output logic [dq_pkg::DATA_W-1:0]     ram_wdata,
  output logic                          ram_re,
  output logic [dq_pkg::ADDR_W-1:0]     ram_raddr,
  input  logic [dq_pkg::DATA_W-1:0]     ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [dq_pkg::ADDR_W-1:0]       front_idx;
  logic [dq_pkg::ADDR_W-1:0]       front_idx_next;
  logic [dq_pkg::CNT_W-1:0]        count;
  logic [dq_pkg::CNT_W-1:0]        count_next;
  logic signed [dq_pkg::DATA_W-1:0] front_val;
  logic signed [dq_pkg::DATA_W-1:0] front_val_next;

  logic                            accept;
  logic                            full;
  logic                            empty;
  logic [dq_pkg::ADDR_W-1:0]       idx_prev;
  logic [dq_pkg::ADDR_W-1:0]       idx_inc;
  logic [dq_pkg::CNT_W:0]          back_sum;
  logic [dq_pkg::CNT_W:0]          back_wrap;
  logic [dq_pkg::ADDR_W-1:0]       back_pos;
  logic [dq_pkg::STATUS_W-1:0]     status;
  logic                            need_read;

  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == dq_pkg::CNT_W'(dq_pkg::CAPACITY));
  assign empty     = (count == '0);

  // Ring neighbors of the front and the slot behind the last element
  assign idx_prev  = (front_idx == '0) ? dq_pkg::ADDR_W'(dq_pkg::CAPACITY - 1)
                                       : front_idx - 1'b1;
  assign idx_inc   = (front_idx == dq_pkg::ADDR_W'(dq_pkg::CAPACITY - 1)) ? '0
                                                                           : front_idx + 1'b1;
  assign back_sum  = (dq_pkg::CNT_W + 1)'(front_idx) + (dq_pkg::CNT_W + 1)'(count);
  assign back_wrap = back_sum - (dq_pkg::CNT_W + 1)'(dq_pkg::CAPACITY);
  assign back_pos  = (back_sum >= (dq_pkg::CNT_W + 1)'(dq_pkg::CAPACITY))
                     ? back_wrap[dq_pkg::ADDR_W-1:0] : back_sum[dq_pkg::ADDR_W-1:0];

  // Decode one accepted operation
  always_comb begin
    front_idx_next = front_idx;
    count_next     = count;
    front_val_next = front_val;
    status         = dq_pkg::ST_OK;
    need_read      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = front_idx;
    ram_wdata      = req.value;
    ram_re         = 1'b0;
    ram_raddr      = idx_inc;
    if (accept) begin
      unique case (req.op)
        dq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status = dq_pkg::ST_PUSH_FULL;
          end else begin
            front_idx_next = idx_prev;
            count_next     = count + 1'b1;
            front_val_next = req.value;
            ram_we         = 1'b1;
            ram_waddr      = idx_prev;
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status = dq_pkg::ST_PUSH_FULL;
          end else begin
            count_next = count + 1'b1;
            ram_we     = 1'b1;
            ram_waddr  = back_pos;
            if (empty) begin
              front_val_next = req.value;
            end
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status = dq_pkg::ST_POP_EMPTY;
          end else begin
            front_idx_next = idx_inc;
            count_next     = count - 1'b1;
            // Fetch the new front element unless the queue drains
            if (count != dq_pkg::CNT_W'(1)) begin
              need_read = 1'b1;
              ram_re    = 1'b1;
            end
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status = dq_pkg::ST_POP_EMPTY;
          end else begin
            count_next = count - 1'b1;
          end
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
    // The fetched front element lands in the cycle after the read
    if (state == S_READ) begin
      front_val_next = ram_rdata;
    end
  end

  // Sequence a front pop through the RAM read
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (need_read) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Build the result: at once for most operations, after the read otherwise
  always_comb begin
    res.status      = status;
    res.front_value = (count_next == '0) ? '0 : front_val_next;
    res.is_empty    = (count_next == '0);
    res.size        = dq_pkg::SIZE_W'(count_next);
    res_valid       = (accept && !need_read) || (state == S_READ);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_idx <= '0;
      count     <= '0;
    end else begin
      state     <= state_next;
      front_idx <= front_idx_next;
      count     <= count_next;
    end
  end

  // Front element copy
  always_ff @(posedge clk) begin
    front_val <= front_val_next;
  end

  // Count never passes the store size
  assert property (@(posedge clk) disable iff (rst)
    count <= dq_pkg::CNT_W'(dq_pkg::CAPACITY))
    else $error("element count above capacity");

  // A push that fits grows the count by one
  assert property (@(posedge clk) disable iff (rst)
    accept && !full && (req.op == dq_pkg::OP_PUSH_FRONT || req.op == dq_pkg::OP_PUSH_BACK)
    |=> count == $past(count) + 1'b1)
    else $error("push did not grow the count");

  // A front pop that leaves elements goes through the read state
  assert property (@(posedge clk) disable iff (rst)
    accept && req.op == dq_pkg::OP_POP_FRONT && count > dq_pkg::CNT_W'(1)
    |=> state == S_READ && res_valid)
    else $error("front pop skipped the RAM read");

  // The RAM is never written and read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("RAM write and read collide");

  // No result is produced while the output stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result produced into a full output stage");

endmodule

FILE: hdl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit values in a circular RAM store.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op[2:0], value[31:0]
//   rsp      out  valid/ready   status[1:0], front_value[31:0], is_empty, size[10:0]
//
// Pushes, back pops and queries form their result as they are accepted; a front
// pop that leaves elements passes through a read of the new front from the RAM.
// The response register lets a new request in during the cycle its result is
// taken; while a response stalls, req.ready stays low.
// Synchronous reset empties the queue at once; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
  input  logic    clk,
  input  logic    rst,
  dq_req_if.sink  req,
  dq_rsp_if.source rsp
);

  dq_pkg::dq_res_t              res;
  logic                         res_valid;
  logic                         out_free;
  logic                         ram_we;
  logic [dq_pkg::ADDR_W-1:0]    ram_waddr;
  logic [dq_pkg::DATA_W-1:0]    ram_wdata;
  logic                         ram_re;
  logic [dq_pkg::ADDR_W-1:0]    ram_raddr;
  logic [dq_pkg::DATA_W-1:0]    ram_rdata;

  assign out_free = !rsp.valid || rsp.ready;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold the response until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Load the response payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp.status      <= res.status;
      rsp.front_value <= res.front_value;
      rsp.is_empty    <= res.is_empty;
      rsp.size        <= res.size;
    end
  end

endmodule

FILE: tb/sv/double_ended_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the double-ended queue. A tracker class keeps its
// own copy of the ring store, front position and count. It predicts the
// response of every accepted request and checks the responses in order.
// Stimulus runs through the corner operations first. Random phases follow:
// short mixed traffic, a fill to capacity, pushes against the full store,
// and a short pop-heavy mix. Bursty requests meet a stalling receiver.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;

  // Op codes with no defined operation; the block treats them as a query
  localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // Tracks the queue contents and holds the responses still owed by the block
  class deque_tracker;
    localparam int REPORT_MAX = 10;

    logic signed [dq_pkg::DATA_W-1:0] slots [dq_pkg::CAPACITY];
    int unsigned                      head_pos;
    int unsigned                      held;
    dq_pkg::dq_res_t                  owed_responses [$];
    int unsigned                      mismatches;

    function new();
      head_pos   = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    // Apply one operation to the tracked queue and form its response
    function dq_pkg::dq_res_t apply_op(logic [dq_pkg::OP_W-1:0] op,
                                       logic signed [dq_pkg::DATA_W-1:0] value);
      dq_pkg::dq_res_t res;
      res.status = dq_pkg::ST_OK;
      case (op)
        dq_pkg::OP_PUSH_FRONT: begin
          if (held >= dq_pkg::CAPACITY) begin
            res.status = dq_pkg::ST_PUSH_FULL;
          end else begin
            head_pos        = (head_pos + dq_pkg::CAPACITY - 1) % dq_pkg::CAPACITY;
            slots[head_pos] = value;
            held++;
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (held >= dq_pkg::CAPACITY) begin
            res.status = dq_pkg::ST_PUSH_FULL;
          end else begin
            slots[(head_pos + held) % dq_pkg::CAPACITY] = value;
            held++;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (held == 0) begin
            res.status = dq_pkg::ST_POP_EMPTY;
          end else begin
            head_pos = (head_pos + 1) % dq_pkg::CAPACITY;
            held--;
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (held == 0) begin
            res.status = dq_pkg::ST_POP_EMPTY;
          end else begin
            held--;
          end
        end
        default: begin
        end
      endcase
      res.front_value = (held != 0) ? slots[head_pos] : '0;
      res.is_empty    = (held == 0);
      res.size        = dq_pkg::SIZE_W'(held);
      return res;
    endfunction

    function void note_request(logic [dq_pkg::OP_W-1:0] op,
                               logic signed [dq_pkg::DATA_W-1:0] value);
      owed_responses.push_back(apply_op(op, value));
    endfunction

    function void check_response(dq_pkg::dq_res_t got);
      dq_pkg::dq_res_t want;
      if (owed_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected response: status=%0d front=%0d empty=%0b size=%0d",
                   got.status, got.front_value, got.is_empty, got.size);
        return;
      end
      want = owed_responses.pop_front();
      if (got.status !== want.status || got.front_value !== want.front_value ||
          got.is_empty !== want.is_empty || got.size !== want.size) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("response mismatch: exp status=%0d front=%0d empty=%0b size=%0d",
                   want.status, want.front_value, want.is_empty, want.size);
          $display("                   got status=%0d front=%0d empty=%0b size=%0d",
                   got.status, got.front_value, got.is_empty, got.size);
        end
      end
    endfunction

    function int unsigned owed();
      return owed_responses.size();
    endfunction

    function int unsigned fill_level();
      return held;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  dq_req_if req ();
  dq_rsp_if rsp ();

  double_ended_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  deque_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          gaps_enabled = 1'b1;

  // Free-running clock
  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: switch among always-ready, random, periodic and long-stall modes
  always @(negedge clk) begin : rsp_stall
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    int unsigned tick;
    if (mode_left == 0) begin
      mode      = $urandom_range(3);
      mode_left = $urandom_range(256, 32);
    end
    mode_left--;
    tick++;
    case (mode)
      0: rsp.ready = 1'b1;
      1: rsp.ready = ($urandom_range(3) != 0);
      2: rsp.ready = (tick % 3 == 0);
      default: begin
        if (stall_left == 0) begin
          rsp.ready  = 1'b1;
          stall_left = $urandom_range(12);
        end else begin
          rsp.ready = 1'b0;
          stall_left--;
        end
      end
    endcase
  end

  // Check every response transfer against the oldest owed response
  always @(posedge clk) begin : rsp_monitor
    dq_pkg::dq_res_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status      = rsp.status;
      got.front_value = rsp.front_value;
      got.is_empty    = rsp.is_empty;
      got.size        = rsp.size;
      tracker.check_response(got);
    end
  end

  // Drive one request, idling between bursts, and note it once transferred
  task automatic send_item(input logic [dq_pkg::OP_W-1:0] op,
                           input logic signed [dq_pkg::DATA_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gaps_enabled && $urandom_range(3) != 0) ? $urandom_range(6, 1) : 0;
      repeat (gap) begin
        @(negedge clk);
        req.valid = 1'b0;
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    @(negedge clk);
    req.valid = 1'b1;
    req.op    = op;
    req.value = value;
    do @(posedge clk); while (!req.ready);
    tracker.note_request(op, value);
  endtask

  // Hold requests off until every owed response has come back
  task automatic hold_until_drained();
    @(negedge clk);
    req.valid = 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [dq_pkg::OP_W-1:0] pick_op(int unsigned push_pct,
                                                      int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct)
      return $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
    return dq_pkg::OP_W'($urandom_range(OP_UNUSED_HI, dq_pkg::OP_QUERY));
  endfunction

  function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    req.valid = 1'b0;
    req.op    = dq_pkg::OP_QUERY;
    req.value = '0;
    rsp.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pops and queries on the empty queue, unused codes
    send_item(dq_pkg::OP_POP_FRONT, 32'h1234_5678);
    send_item(dq_pkg::OP_POP_BACK, 32'h8765_4321);
    send_item(dq_pkg::OP_QUERY, 32'hFFFF_FFFF);
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
      send_item(dq_pkg::OP_W'(c), 32'h5A5A_A5A5);

    // Directed: value extremes at both ends
    send_item(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(dq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_item(dq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    send_item(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_item(dq_pkg::OP_PUSH_BACK, 32'h5555_5555);
    send_item(dq_pkg::OP_QUERY, 32'h0F0F_0F0F);

    // Directed: alternate pops, then empty the queue from the front
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_BACK, '0);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_BACK, '0);
    send_item(dq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_BACK, '0);
    send_item(dq_pkg::OP_POP_FRONT, '0);
    send_item(dq_pkg::OP_POP_BACK, '0);

    hold_until_drained();

    // Random mixed traffic around a small fill level
    repeat (30) send_item(pick_op(40, 40), pick_value());
    hold_until_drained();

    // Fill to capacity without sender gaps, then push against the full store
    gaps_enabled = 1'b0;
    while (tracker.fill_level() < dq_pkg::CAPACITY) send_item(pick_op(100, 0), pick_value());
    gaps_enabled = 1'b1;
    repeat (12) send_item(pick_op(60, 10), pick_value());
    hold_until_drained();

    // Final pop-heavy traffic from the store left by the push phase
    repeat (12) send_item(pick_op(20, 60), pick_value());

    @(negedge clk);
    req.valid = 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.owed() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
